>>> rtl/lifting_dwt53_1d_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 5/3 lifting wavelet block
// Shared clocked assertion forms, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LIFTING_DWT53_1D_TOP_ASSERT_SVH
`define LIFTING_DWT53_1D_TOP_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define LDWT53_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define LDWT53_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/ldwt53_pkg.sv
// ----------------------------------------------------------------------------
// ldwt53_pkg
// Types, constants and lifting helper functions for the 5/3 wavelet block.
// ----------------------------------------------------------------------------
package ldwt53_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned MAX_LEN  = 65536;
  localparam int unsigned MAX_RES  = 3;
  localparam int unsigned CNT_W    = 2;
  localparam int unsigned RQ_AW    = 2;
  localparam int unsigned RQ_DEPTH = 1 << RQ_AW;

  // Largest reportable position, held one bit wider than a position.
  localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(MAX_LEN - 1);
  // Saturation point of the pair counter.
  localparam logic [POS_W-1:0] PAIR_LIMIT = POS_W'(MAX_LEN - 1);

  localparam logic BAND_LOW  = 1'b0;
  localparam logic BAND_HIGH = 1'b1;
  localparam logic DIR_FWD   = 1'b0;
  localparam logic DIR_INV   = 1'b1;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              band;
    logic [POS_W-1:0]  pos;
    logic              fin;
  } res_t;

  // All results caused by one input transaction, in delivery order.
  typedef struct packed {
    res_t [MAX_RES-1:0] items;
    logic [CNT_W-1:0]   cnt;
  } bundle_t;

  // Predict step: (a + b) >> 1, wrapping sum, arithmetic shift.
  function automatic logic [DATA_W-1:0] predict(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b;
    return $unsigned($signed(s) >>> 1);
  endfunction

  // Update step: (a + b + 2) >> 2, wrapping sum, arithmetic shift.
  function automatic logic [DATA_W-1:0] update(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b + DATA_W'(2);
    return $unsigned($signed(s) >>> 2);
  endfunction

  // Build a result, clamping the position to the longest line.
  function automatic res_t mk_res(input logic [DATA_W-1:0] value,
                                  input logic              band,
                                  input logic [POS_W:0]    pos,
                                  input logic              fin);
    res_t r;
    r.value = value;
    r.band  = band;
    r.pos   = (pos > POS_LIMIT) ? POS_LIMIT[POS_W-1:0] : pos[POS_W-1:0];
    r.fin   = fin;
    return r;
  endfunction

endpackage

>>> rtl/ldwt53_lift.sv
// ----------------------------------------------------------------------------
// ldwt53_lift
// Lifting state and the combinational predict/update datapath. Produces the
// bundle of results caused by the transaction accepted in this cycle.
// ----------------------------------------------------------------------------
`include "lifting_dwt53_1d_top_assert.svh"

module ldwt53_lift (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              in_acc,
  input  logic [ldwt53_pkg::DATA_W-1:0]     in_x,
  input  logic                              in_last,
  output ldwt53_pkg::bundle_t               bnd
);

  // Control state.
  logic                          dir_r, dir_nxt;
  logic                          odd_phase_r, odd_phase_nxt;
  logic                          first_pair_r, first_pair_nxt;
  logic [ldwt53_pkg::POS_W-1:0]  pair_idx_r, pair_idx_nxt;

  // Held data.
  logic [ldwt53_pkg::DATA_W-1:0] held_even_r, held_even_nxt;
  logic [ldwt53_pkg::DATA_W-1:0] held_odd_r, held_odd_nxt;
  logic [ldwt53_pkg::DATA_W-1:0] prev_high_r, prev_high_nxt;
  logic [ldwt53_pkg::DATA_W-1:0] prev_even_r, prev_even_nxt;

  // Datapath and next-state logic for one transaction.
  always_comb begin
    logic [ldwt53_pkg::DATA_W-1:0] h;
    logic [ldwt53_pkg::DATA_W-1:0] hl;
    logic [ldwt53_pkg::DATA_W-1:0] lo;
    logic [ldwt53_pkg::DATA_W-1:0] lk;
    logic [ldwt53_pkg::DATA_W-1:0] ext;
    logic [ldwt53_pkg::POS_W:0]    k17;
    logic [ldwt53_pkg::POS_W:0]    k2;
    logic [ldwt53_pkg::CNT_W-1:0]  n;

    h   = '0;
    hl  = '0;
    lo  = '0;
    lk  = '0;
    ext = '0;
    n   = '0;
    k17 = {1'b0, pair_idx_r};
    k2  = {pair_idx_r, 1'b0};

    bnd.items = '0;
    bnd.cnt   = '0;

    dir_nxt        = dir_r;
    odd_phase_nxt  = odd_phase_r;
    first_pair_nxt = first_pair_r;
    pair_idx_nxt   = pair_idx_r;
    held_even_nxt  = held_even_r;
    held_odd_nxt   = held_odd_r;
    prev_high_nxt  = prev_high_r;
    prev_even_nxt  = prev_even_r;

    if (in_acc) begin
      if (!odd_phase_r) begin
        // Even position: closes the previous pair.
        if (pair_idx_r == '0) begin
          if (in_last) begin
            bnd.items[n] = ldwt53_pkg::mk_res(in_x, ldwt53_pkg::BAND_LOW, '0, 1'b1);
            n = n + 1'b1;
          end
        end else if (dir_r == ldwt53_pkg::DIR_FWD) begin
          h  = held_odd_r - ldwt53_pkg::predict(held_even_r, in_x);
          hl = first_pair_r ? h : prev_high_r;
          lo = held_even_r + ldwt53_pkg::update(hl, h);
          bnd.items[n] = ldwt53_pkg::mk_res(lo, ldwt53_pkg::BAND_LOW,
                                            k17 - 1'b1, 1'b0);
          n = n + 1'b1;
          bnd.items[n] = ldwt53_pkg::mk_res(h, ldwt53_pkg::BAND_HIGH,
                                            k17 - 1'b1, 1'b0);
          n = n + 1'b1;
          if (in_last) begin
            // Mirrored high neighbour past the end of the line.
            ext = in_x + ldwt53_pkg::update(h, h);
            bnd.items[n] = ldwt53_pkg::mk_res(ext, ldwt53_pkg::BAND_LOW, k17, 1'b1);
            n = n + 1'b1;
          end
          prev_high_nxt  = h;
          first_pair_nxt = 1'b0;
        end else if (in_last) begin
          lk  = in_x - ldwt53_pkg::update(prev_high_r, prev_high_r);
          ext = prev_high_r + ldwt53_pkg::predict(prev_even_r, lk);
          bnd.items[n] = ldwt53_pkg::mk_res(ext, ldwt53_pkg::BAND_LOW,
                                            k2 - 1'b1, 1'b0);
          n = n + 1'b1;
          bnd.items[n] = ldwt53_pkg::mk_res(lk, ldwt53_pkg::BAND_LOW, k2, 1'b1);
          n = n + 1'b1;
        end
        held_even_nxt = in_x;
        odd_phase_nxt = 1'b1;
      end else begin
        // Odd position.
        held_odd_nxt = in_x;
        if (dir_r == ldwt53_pkg::DIR_FWD) begin
          if (in_last) begin
            h  = in_x - ldwt53_pkg::predict(held_even_r, held_even_r);
            hl = first_pair_r ? h : prev_high_r;
            lo = held_even_r + ldwt53_pkg::update(hl, h);
            bnd.items[n] = ldwt53_pkg::mk_res(lo, ldwt53_pkg::BAND_LOW, k17, 1'b0);
            n = n + 1'b1;
            bnd.items[n] = ldwt53_pkg::mk_res(h, ldwt53_pkg::BAND_HIGH, k17, 1'b1);
            n = n + 1'b1;
          end
        end else begin
          lk = held_even_r - ldwt53_pkg::update(first_pair_r ? in_x : prev_high_r, in_x);
          if (!first_pair_r && (pair_idx_r != '0)) begin
            ext = prev_high_r + ldwt53_pkg::predict(prev_even_r, lk);
            bnd.items[n] = ldwt53_pkg::mk_res(ext, ldwt53_pkg::BAND_LOW,
                                              k2 - 1'b1, 1'b0);
            n = n + 1'b1;
          end
          bnd.items[n] = ldwt53_pkg::mk_res(lk, ldwt53_pkg::BAND_LOW, k2, 1'b0);
          n = n + 1'b1;
          if (in_last) begin
            lo = in_x + ldwt53_pkg::predict(lk, lk);
            bnd.items[n] = ldwt53_pkg::mk_res(lo, ldwt53_pkg::BAND_LOW,
                                              {pair_idx_r, 1'b1}, 1'b1);
            n = n + 1'b1;
          end
          prev_high_nxt  = in_x;
          prev_even_nxt  = lk;
          first_pair_nxt = 1'b0;
        end
        odd_phase_nxt = 1'b0;
        if (pair_idx_r < ldwt53_pkg::PAIR_LIMIT) begin
          pair_idx_nxt = pair_idx_r + 1'b1;
        end
      end

      // End of line: restart for the next one.
      if (in_last) begin
        odd_phase_nxt  = 1'b0;
        first_pair_nxt = 1'b1;
        pair_idx_nxt   = '0;
      end
    end

    bnd.cnt = n;

    // A direction write restarts the line as well.
    if (cfg_wr_en) begin
      dir_nxt        = cfg_wr_data;
      odd_phase_nxt  = 1'b0;
      first_pair_nxt = 1'b1;
      pair_idx_nxt   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r        <= ldwt53_pkg::DIR_FWD;
      odd_phase_r  <= 1'b0;
      first_pair_r <= 1'b1;
      pair_idx_r   <= '0;
    end else begin
      dir_r        <= dir_nxt;
      odd_phase_r  <= odd_phase_nxt;
      first_pair_r <= first_pair_nxt;
      pair_idx_r   <= pair_idx_nxt;
    end
  end

  // Held data registers.
  always_ff @(posedge clk) begin
    held_even_r <= held_even_nxt;
    held_odd_r  <= held_odd_nxt;
    prev_high_r <= prev_high_nxt;
    prev_even_r <= prev_even_nxt;
  end

  // Three results only ever come from a line end.
  `LDWT53_NEVER(a_three_only_at_end, in_acc && !in_last && (bnd.cnt == 2'd3), "three results without line end")
  // A line end always yields a result carrying the final flag.
  `LDWT53_NEVER(a_end_gives_result, in_acc && in_last && (bnd.cnt == '0), "line end without result")
  // Pair counter returns to zero after a line end.
  `LDWT53_ASSERT(a_restart_after_end, (in_acc && in_last) |=> (pair_idx_r == '0 && first_pair_r), "line did not restart")

endmodule

>>> rtl/ldwt53_rqueue.sv
// ----------------------------------------------------------------------------
// ldwt53_rqueue
// Small queue of result bundles with an output serialiser that delivers one
// result transaction per cycle while results are queued and the receiver is ready.
// ----------------------------------------------------------------------------
`include "lifting_dwt53_1d_top_assert.svh"

module ldwt53_rqueue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_acc,
  input  ldwt53_pkg::bundle_t push_bnd,
  output logic                push_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output ldwt53_pkg::res_t    res
);

  ldwt53_pkg::bundle_t                 store_r [ldwt53_pkg::RQ_DEPTH];
  logic [ldwt53_pkg::RQ_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [ldwt53_pkg::RQ_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [ldwt53_pkg::RQ_AW:0]          count_r, count_nxt;
  logic [ldwt53_pkg::CNT_W-1:0]        sub_r, sub_nxt;
  ldwt53_pkg::bundle_t                 head;
  logic                                push;
  logic                                pop;
  logic                                res_acc;

  // Head of queue and the result within it.
  assign head       = store_r[rd_ptr_r];
  assign res        = head.items[sub_r];
  assign res_valid  = (count_r != '0);
  assign push_ready = (count_r != (ldwt53_pkg::RQ_AW + 1)'(ldwt53_pkg::RQ_DEPTH));
  assign res_acc    = res_valid && res_ready;
  assign pop        = res_acc && (sub_r == (head.cnt - 1'b1));
  assign push       = push_acc && (push_bnd.cnt != '0);

  // Pointer, occupancy and serialiser next state.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{ldwt53_pkg::RQ_AW{1'b0}}, push}
                         - {{ldwt53_pkg::RQ_AW{1'b0}}, pop};
    if (pop) begin
      sub_nxt = '0;
    end else if (res_acc) begin
      sub_nxt = sub_r + 1'b1;
    end else begin
      sub_nxt = sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

  // Bundle storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_bnd;
    end
  end

  // Only non-empty bundles are queued.
  `LDWT53_NEVER(a_head_not_empty, res_valid && (head.cnt == '0), "empty bundle at head")
  // The serialiser never runs past the bundle it is delivering.
  `LDWT53_NEVER(a_sub_in_range, res_valid && (sub_r >= head.cnt), "result index past bundle")
  // Occupancy falls by one on a pop without a push.
  `LDWT53_ASSERT(a_count_drop, (pop && !push) |=> (count_r == $past(count_r) - 1'b1), "occupancy did not fall")

endmodule

>>> rtl/lifting_dwt53_1d_top.sv
// ----------------------------------------------------------------------------
// lifting_dwt53_1d_top
// Reversible 5/3 integer lifting wavelet, one dimension, forward or inverse.
//
//   Port group  Dir  Contents
//   in_*        in   sample or interleaved coefficient, tlast ends a line
//   out_*       out  coefficient or sample with position, tuser band,
//                    tlast on the last result of a line
//   cfg_*       in   transform direction, 0 forward, 1 inverse
//
// One input transaction is taken per cycle while the result queue has room;
// its results are queued and leave one per cycle while the receiver is ready.
// Each transaction yields up to three results; the four-bundle result queue
// decouples the sides: the input moves on while the output stalls, until full.
// Reset clears the control state; there is no clearing pass.
// ----------------------------------------------------------------------------
module lifting_dwt53_1d_top (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // transform_direction
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] sample_value
  input  logic        in_tlast,      // line_end
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // [31:0] result_value, [47:32] position
  output logic        out_tuser,     // band
  output logic        out_tlast      // final_result
);

  ldwt53_pkg::bundle_t bnd;
  ldwt53_pkg::res_t    res;
  logic                in_acc;

  assign in_acc = in_tvalid && in_tready;

  // Lifting datapath and line state.
  ldwt53_lift u_lift (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_acc      (in_acc),
    .in_x        (in_tdata),
    .in_last     (in_tlast),
    .bnd         (bnd)
  );

  // Result queue and serialiser.
  ldwt53_rqueue u_rqueue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_acc   (in_acc),
    .push_bnd   (bnd),
    .push_ready (in_tready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // Result transaction packing.
  assign out_tdata = {res.pos, res.value};
  assign out_tuser = res.band;
  assign out_tlast = res.fin;

endmodule

>>> verif/lifting_dwt53_1d_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifting_dwt53_1d_top_tb
// Self-checking bench for the 5/3 lifting wavelet. A short table of directed
// transactions covers single-item lines, extreme samples, both directions and
// a direction write in the middle of a line. Random lines in alternating
// directions follow. Every result is compared, field by field and in arrival
// order, with a typed-in value or a cycle-free predictor of the lifting steps.
// ----------------------------------------------------------------------------
module lifting_dwt53_1d_top_tb;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int MAX_REPORTS = 40;
  localparam int PREDICTED   = -1;
  localparam logic [31:0] POS_CEIL = ldwt53_pkg::MAX_LEN - 1;

  typedef enum logic {ROW_ITEM, ROW_DIR} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_THIRDS, RX_COIN, RX_STARVED} rx_mode_t;

  // One row of the directed table: a transaction or a direction write.
  typedef struct {
    row_kind_t          kind;
    logic [31:0]        value;
    logic               last;
    int                 typed;
    ldwt53_pkg::res_t   want;
  } row_t;

  localparam ldwt53_pkg::res_t NO_RES = '0;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  lifting_dwt53_1d_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // Lifting state mirrored from the block, as it stands after reset.
  logic        xform_dir     = ldwt53_pkg::DIR_FWD;
  logic [31:0] even_hold     = '0;
  logic [31:0] odd_hold      = '0;
  logic [31:0] last_high     = '0;
  logic [31:0] last_even_rec = '0;
  int unsigned pair_cnt      = 0;
  logic        in_odd        = 1'b0;
  logic        line_start    = 1'b1;

  ldwt53_pkg::res_t step_res [3];
  int               step_cnt;
  ldwt53_pkg::res_t coef_expect [$];
  int               errors      = 0;
  int               coefs_seen  = 0;
  int               burst_left  = 0;

  // Directed transactions. Results that are obvious are typed in; the rest
  // come from the predictor.
  row_t plan [29] = '{
    // Forward: single-item lines at both extremes pass straight through.
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1,
      '{32'h7FFF_FFFF, ldwt53_pkg::BAND_LOW, 16'd0, 1'b1}},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, 1,
      '{32'h8000_0000, ldwt53_pkg::BAND_LOW, 16'd0, 1'b1}},
    // Two-item line mixing the extremes, so the sums wrap.
    '{ROW_ITEM, 32'h8000_0000, 1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b1, PREDICTED, NO_RES},
    // Odd-length line, ending on an even position.
    '{ROW_ITEM, 32'd1,         1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'd2,         1'b0, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'd3,         1'b0, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'd4,         1'b0, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'd5,         1'b1, PREDICTED, NO_RES},
    // Line left open, then restarted by a direction write.
    '{ROW_ITEM, 32'h0000_000A, 1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'h0000_0014, 1'b0, PREDICTED, NO_RES},
    '{ROW_DIR,  {31'd0, ldwt53_pkg::DIR_FWD}, 1'b0, 0, NO_RES},
    '{ROW_ITEM, 32'd7,         1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'd8,         1'b1, PREDICTED, NO_RES},
    // Inverse direction.
    '{ROW_DIR,  {31'd0, ldwt53_pkg::DIR_INV}, 1'b0, 0, NO_RES},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, 1,
      '{32'h8000_0000, ldwt53_pkg::BAND_LOW, 16'd0, 1'b1}},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'd5,         1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'hFFFF_FFFD, 1'b0, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'd9,         1'b1, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'd100,       1'b0, 0,         NO_RES},
    '{ROW_ITEM, 32'hFFFF_FFF9, 1'b0, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, PREDICTED, NO_RES},
    '{ROW_ITEM, 32'h8000_0000, 1'b1, PREDICTED, NO_RES},
    // Open inverse line restarted by rewriting the same direction.
    '{ROW_ITEM, 32'd3,         1'b0, 0,         NO_RES},
    '{ROW_DIR,  {31'd0, ldwt53_pkg::DIR_INV}, 1'b0, 0, NO_RES},
    '{ROW_ITEM, 32'd4,         1'b1, 1,
      '{32'd4, ldwt53_pkg::BAND_LOW, 16'd0, 1'b1}},
    '{ROW_DIR,  {31'd0, ldwt53_pkg::DIR_FWD}, 1'b0, 0, NO_RES}
  };

  // Clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("lifting_dwt53_1d_top regression: fail");
    $finish;
  end

  // (a + b) >> 1 with a wrapping sum and the sign bit copied in.
  function automatic logic [31:0] halve_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return {s[31], s[31:1]};
  endfunction

  // (a + b + 2) >> 2 with a wrapping sum and the sign bit copied in.
  function automatic logic [31:0] quarter_round(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b + 32'd2;
    return {{2{s[31]}}, s[31:2]};
  endfunction

  task automatic add_res(input logic [31:0] value, input logic band,
                         input logic [31:0] pos, input logic fin);
    step_res[step_cnt].value = value;
    step_res[step_cnt].band  = band;
    step_res[step_cnt].pos   = (pos > POS_CEIL) ? POS_CEIL[15:0] : pos[15:0];
    step_res[step_cnt].fin   = fin;
    step_cnt++;
  endtask

  task automatic restart_line();
    in_odd     = 1'b0;
    line_start = 1'b1;
    pair_cnt   = 0;
  endtask

  // Advance the lifting state by one transaction and collect its results.
  task automatic lift_step(input logic [31:0] x, input logic last);
    logic [31:0] k;
    logic [31:0] h;
    logic [31:0] hl;
    logic [31:0] lk;
    k = pair_cnt;
    step_cnt = 0;
    if (!in_odd) begin
      if (k == 0) begin
        if (last) add_res(x, ldwt53_pkg::BAND_LOW, 32'd0, 1'b1);
      end else if (xform_dir == ldwt53_pkg::DIR_FWD) begin
        h  = odd_hold - halve_sum(even_hold, x);
        hl = line_start ? h : last_high;
        add_res(even_hold + quarter_round(hl, h), ldwt53_pkg::BAND_LOW, k - 1, 1'b0);
        add_res(h, ldwt53_pkg::BAND_HIGH, k - 1, 1'b0);
        if (last) add_res(x + quarter_round(h, h), ldwt53_pkg::BAND_LOW, k, 1'b1);
        last_high  = h;
        line_start = 1'b0;
      end else if (last) begin
        // Inverse line ending on a low coefficient: mirror the last high one.
        lk = x - quarter_round(last_high, last_high);
        add_res(last_high + halve_sum(last_even_rec, lk), ldwt53_pkg::BAND_LOW,
                2 * k - 1, 1'b0);
        add_res(lk, ldwt53_pkg::BAND_LOW, 2 * k, 1'b1);
      end
      even_hold = x;
      in_odd    = 1'b1;
    end else begin
      odd_hold = x;
      if (xform_dir == ldwt53_pkg::DIR_FWD) begin
        if (last) begin
          h  = x - halve_sum(even_hold, even_hold);
          hl = line_start ? h : last_high;
          add_res(even_hold + quarter_round(hl, h), ldwt53_pkg::BAND_LOW, k, 1'b0);
          add_res(h, ldwt53_pkg::BAND_HIGH, k, 1'b1);
        end
      end else begin
        lk = even_hold - quarter_round(line_start ? x : last_high, x);
        if (!line_start && k != 0)
          add_res(last_high + halve_sum(last_even_rec, lk), ldwt53_pkg::BAND_LOW,
                  2 * k - 1, 1'b0);
        add_res(lk, ldwt53_pkg::BAND_LOW, 2 * k, 1'b0);
        if (last) add_res(x + halve_sum(lk, lk), ldwt53_pkg::BAND_LOW, 2 * k + 1, 1'b1);
        last_high     = x;
        last_even_rec = lk;
        line_start    = 1'b0;
      end
      in_odd = 1'b0;
      if (pair_cnt < ldwt53_pkg::MAX_LEN - 1) pair_cnt++;
    end
    if (last) restart_line();
  endtask

  // Offer one transaction in bursts with random gaps; book its results once
  // it has been accepted. Called and returning at a falling edge.
  task automatic send_item(input logic [31:0] sample, input logic line_end,
                           input int typed, input ldwt53_pkg::res_t want);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tlast  <= line_end;
    do @(posedge clk); while (!in_tready);
    lift_step(sample, line_end);
    if (typed == PREDICTED) begin
      for (int i = 0; i < step_cnt; i++) coef_expect.push_back(step_res[i]);
    end else if (typed == 1) begin
      coef_expect.push_back(want);
    end
    @(negedge clk);
  endtask

  // Write the direction once the block has gone quiet.
  task automatic set_direction(input logic dir);
    in_tvalid <= 1'b0;
    while (coef_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dir;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    xform_dir = dir;
    restart_line();
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 16) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // Mostly short lines, some single items and a few longer ones.
  function automatic int pick_line_len();
    case ($urandom_range(0, 9))
      0, 1:    return 1;
      8:       return $urandom_range(9, 24);
      9:       return $urandom_range(25, 60);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_REPORTS)
      $display("mismatch in %s at result %0d: got %h, expected %h", what, coefs_seen, got, want);
    errors++;
  endtask

  // Receiver stalls, switching between patterns of random length.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 40);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:    out_tready <= 1'b1;
        RX_THIRDS:  out_tready <= (rx_tick % 3) != 0;
        RX_COIN:    out_tready <= 1'($urandom_range(0, 1));
        RX_STARVED: out_tready <= (rx_tick % 8) < 2;
        default:    out_tready <= 1'b1;
      endcase
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    ldwt53_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (coef_expect.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata[31:0], 32'd0);
      end else begin
        want = coef_expect.pop_front();
        if (out_tdata[31:0] !== want.value)
          report_mismatch("value", out_tdata[31:0], want.value);
        if (out_tuser !== want.band)
          report_mismatch("band", {31'd0, out_tuser}, {31'd0, want.band});
        if (out_tdata[47:32] !== want.pos)
          report_mismatch("position", {16'd0, out_tdata[47:32]}, {16'd0, want.pos});
        if (out_tlast !== want.fin)
          report_mismatch("last flag", {31'd0, out_tlast}, {31'd0, want.fin});
      end
      coefs_seen++;
    end
  end

  // Stimulus.
  initial begin
    int len;
    int sent;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_DIR) set_direction(plan[r].value[0]);
      else send_item(plan[r].value, plan[r].last, plan[r].typed, plan[r].want);
    end

    // Random lines, alternating direction; some phases end with a line left
    // open so that the direction write has to restart it.
    for (int phase = 0; phase < 6; phase++) begin
      set_direction((phase % 2) ? ldwt53_pkg::DIR_INV : ldwt53_pkg::DIR_FWD);
      sent = 0;
      while (sent < 60) begin
        len = pick_line_len();
        for (int i = 0; i < len; i++) send_item(pick_sample(), i == len - 1, PREDICTED, NO_RES);
        sent += len;
      end
      if ($urandom_range(0, 1))
        repeat ($urandom_range(1, 3)) send_item(pick_sample(), 1'b0, PREDICTED, NO_RES);
    end

    // Drain and let the queue settle.
    in_tvalid <= 1'b0;
    while (coef_expect.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("lifting_dwt53_1d_top regression: pass");
    end else begin
      $display("lifting_dwt53_1d_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ldwt53_pkg.sv
rtl/ldwt53_lift.sv
rtl/ldwt53_rqueue.sv
rtl/lifting_dwt53_1d_top.sv
verif/lifting_dwt53_1d_top_tb.sv
